// ----- rtl/core/ppp_pkg.sv -----
// ppp_pkg: shared constants, register codes and types for the perspective point projector
// no dependencies
`default_nettype none
package ppp_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int SCREEN_BITS_DEF = 12;
  localparam int COLOR_W         = 24;
  localparam int ADDR_W          = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int FIFO_DEPTH      = 2;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int PITCH_RST  = 640;
  localparam int SCALE_RST  = 554;
  localparam logic [COLOR_W-1:0] COLOR_RST = 24'h00ff00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PITCH  = 3'd2,
    REG_SCALE  = 3'd3,
    REG_COLOR  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/ppp_fifo.sv -----
// ppp_fifo: short show-ahead queue between the front and back parts
// depends on ppp_pkg
`default_nettype none
module ppp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [WIDTH-1:0]   data_i,
  input  wire logic               pop_i,
  output logic [WIDTH-1:0]        data_o,
  output ppp_pkg::fifo_status_t   stat_o
);
  import ppp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ppp_front.sv -----
// ppp_front: accepts vertices, applies the translation and scales X and Y
// depends on ppp_pkg; feeds ppp_fifo
`default_nettype none
module ppp_front #(
  parameter int COORD_BITS  = ppp_pkg::COORD_BITS_DEF,
  parameter int SCREEN_BITS = ppp_pkg::SCREEN_BITS_DEF,
  parameter int SW = COORD_BITS + 1,
  parameter int PW = SW + SCREEN_BITS + 1,
  parameter int FW = 2 * PW + SW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [COORD_BITS-1:0]  vertex_x_i,
  input  wire logic signed [COORD_BITS-1:0]  vertex_y_i,
  input  wire logic signed [COORD_BITS-1:0]  vertex_z_i,
  input  wire logic signed [COORD_BITS-1:0]  offset_x_i,
  input  wire logic signed [COORD_BITS-1:0]  offset_z_i,
  input  wire logic [SCREEN_BITS-1:0]        scale_i,
  input  wire ppp_pkg::fifo_status_t         stat_i,
  output logic                               busy_o,
  output logic                               push_o,
  output logic [FW-1:0]                      data_o
);
  import ppp_pkg::*;

  logic                 valid_q;
  logic                 accept;
  logic signed [SW-1:0] xs, ys, zs;
  logic signed [PW-1:0] sc, px_d, py_d, px_q, py_q;
  logic signed [SW-1:0] z_q;

  assign push_o = valid_q && !stat_i.full;
  assign busy_o = valid_q && stat_i.full;
  assign accept = start_i && !busy_o;

  always_comb begin
    xs   = SW'(vertex_x_i) + SW'(offset_x_i);
    ys   = SW'(vertex_y_i);
    zs   = SW'(vertex_z_i) + SW'(offset_z_i);
    sc   = $signed({{(PW - SCREEN_BITS){1'b0}}, scale_i});
    px_d = PW'(xs) * sc;
    py_d = PW'(ys) * sc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= px_d;
      py_q <= py_d;
      z_q  <= zs;
    end
  end

  assign data_o = {px_q, py_q, z_q};

endmodule
`default_nettype wire

// ----- rtl/core/ppp_div.sv -----
// ppp_div: pipelined restoring divider, one quotient bit per stage, two numerators
// share one divisor; depends on ppp_pkg
`default_nettype none
module ppp_div #(
  parameter int NW   = 8,
  parameter int DW   = 8,
  parameter int SIDE = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [NW-1:0]    num_a_i,
  input  wire logic [NW-1:0]    num_b_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [SIDE-1:0]  side_i,
  output logic                  valid_o,
  output logic [NW-1:0]         quo_a_o,
  output logic [NW-1:0]         quo_b_o,
  output logic [SIDE-1:0]       side_o
);
  import ppp_pkg::*;

  // n holds remaining numerator bits on top, quotient bits shift in at the bottom
  logic            v_q    [NW+1];
  logic [NW-1:0]   na_q   [NW+1];
  logic [NW-1:0]   nb_q   [NW+1];
  logic [DW-1:0]   ra_q   [NW+1];
  logic [DW-1:0]   rb_q   [NW+1];
  logic [DW-1:0]   d_q    [NW+1];
  logic [SIDE-1:0] sd_q   [NW+1];

  always_comb begin
    v_q[0]  = valid_i;
    na_q[0] = num_a_i;
    nb_q[0] = num_b_i;
    ra_q[0] = '0;
    rb_q[0] = '0;
    d_q[0]  = den_i;
    sd_q[0] = side_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0]   ta, tb;
    logic          ga, gb;
    logic [DW-1:0] ra_d, rb_d;

    always_comb begin
      ta   = {ra_q[s], na_q[s][NW-1]};
      tb   = {rb_q[s], nb_q[s][NW-1]};
      ga   = (ta >= {1'b0, d_q[s]});
      gb   = (tb >= {1'b0, d_q[s]});
      ra_d = ga ? DW'(ta - {1'b0, d_q[s]}) : DW'(ta);
      rb_d = gb ? DW'(tb - {1'b0, d_q[s]}) : DW'(tb);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      na_q[s+1] <= {na_q[s][NW-2:0], ga};
      nb_q[s+1] <= {nb_q[s][NW-2:0], gb};
      ra_q[s+1] <= ra_d;
      rb_q[s+1] <= rb_d;
      d_q[s+1]  <= d_q[s];
      sd_q[s+1] <= sd_q[s];
    end
  end

  assign valid_o = v_q[NW];
  assign quo_a_o = na_q[NW];
  assign quo_b_o = nb_q[NW];
  assign side_o  = sd_q[NW];

endmodule
`default_nettype wire

// ----- rtl/core/ppp_back.sv -----
// ppp_back: divides by depth, centres, clips and forms the framebuffer address
// depends on ppp_pkg and ppp_div
`default_nettype none
module ppp_back #(
  parameter int COORD_BITS  = ppp_pkg::COORD_BITS_DEF,
  parameter int SCREEN_BITS = ppp_pkg::SCREEN_BITS_DEF,
  parameter int SW = COORD_BITS + 1,
  parameter int PW = SW + SCREEN_BITS + 1,
  parameter int FW = 2 * PW + SW
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ppp_pkg::fifo_status_t          stat_i,
  input  wire logic [FW-1:0]                  data_i,
  output logic                                pop_o,
  input  wire logic [SCREEN_BITS-1:0]         width_i,
  input  wire logic [SCREEN_BITS-1:0]         height_i,
  input  wire logic [SCREEN_BITS-1:0]         pitch_i,
  input  wire logic [ppp_pkg::COLOR_W-1:0]    color_i,
  output logic                                valid_o,
  output logic                                plot_o,
  output logic [SCREEN_BITS-1:0]              pixel_x_o,
  output logic [SCREEN_BITS-1:0]              pixel_y_o,
  output logic [ppp_pkg::ADDR_W-1:0]          pixel_address_o,
  output logic [ppp_pkg::COLOR_W-1:0]         color_out_o,
  output logic                                depth_zero_o
);
  import ppp_pkg::*;

  localparam int MW = PW - 1;   // magnitude of a product
  localparam int DW = SW;       // magnitude of the depth
  localparam int QW = MW + 1;   // signed quotient
  localparam int XW = MW + 2;   // quotient plus centre

  logic signed [PW-1:0] px, py;
  logic signed [SW-1:0] pz;

  logic          s0_v_q;
  logic [MW-1:0] s0_ma_q, s0_mb_q;
  logic [DW-1:0] s0_md_q;
  logic [2:0]    s0_sd_q;

  logic          dv;
  logic [MW-1:0] qa, qb;
  logic [2:0]    dsd;

  logic                 sa_v_q, sa_dz_q;
  logic signed [QW-1:0] sa_qx_q, sa_qy_q;

  logic signed [XW-1:0] xp, yp;
  logic                 onscr;

  logic                   sb_v_q, sb_plot_q, sb_dz_q;
  logic [SCREEN_BITS-1:0] sb_x_q, sb_y_q;

  assign pop_o = !stat_i.empty;
  assign {px, py, pz} = data_i;

  // stage 0: sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_ma_q <= px[PW-1] ? MW'(-px) : MW'(px);
    s0_mb_q <= py[PW-1] ? MW'(-py) : MW'(py);
    s0_md_q <= pz[SW-1] ? DW'(-pz) : DW'(pz);
    s0_sd_q <= {px[PW-1] ^ pz[SW-1], py[PW-1] ^ pz[SW-1], (pz == '0)};
  end

  ppp_div #(
    .NW   (MW),
    .DW   (DW),
    .SIDE (3)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .num_a_i (s0_ma_q),
    .num_b_i (s0_mb_q),
    .den_i   (s0_md_q),
    .side_i  (s0_sd_q),
    .valid_o (dv),
    .quo_a_o (qa),
    .quo_b_o (qb),
    .side_o  (dsd)
  );

  // stage a: restore the sign, truncating toward zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else begin
      sa_v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_qx_q <= dsd[2] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    sa_qy_q <= dsd[1] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
    sa_dz_q <= dsd[0];
  end

  // stage b: centre and clip
  always_comb begin
    xp = XW'(sa_qx_q) + XW'($signed({1'b0, width_i[SCREEN_BITS-1:1]}));
    yp = XW'(sa_qy_q) + XW'($signed({1'b0, height_i[SCREEN_BITS-1:1]}));
    onscr = !sa_dz_q
         && !xp[XW-1] && (xp < XW'($signed({1'b0, width_i})))
         && !yp[XW-1] && (yp < XW'($signed({1'b0, height_i})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else begin
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_plot_q <= onscr;
    sb_dz_q   <= sa_dz_q;
    sb_x_q    <= onscr ? SCREEN_BITS'(xp) : '0;
    sb_y_q    <= onscr ? SCREEN_BITS'(yp) : '0;
  end

  // output stage: address and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plot_o          <= sb_plot_q;
    pixel_x_o       <= sb_x_q;
    pixel_y_o       <= sb_y_q;
    pixel_address_o <= ADDR_W'(ADDR_W'(sb_x_q) + ADDR_W'(sb_y_q) * ADDR_W'(pitch_i));
    color_out_o     <= color_i;
    depth_zero_o    <= sb_dz_q;
  end

endmodule
`default_nettype wire

// ----- rtl/core/perspective_point_projector.sv -----
// perspective_point_projector: top level, configuration registers and the
// front / queue / back split; depends on ppp_pkg, ppp_front, ppp_fifo, ppp_back
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  vertex   | start_i, busy_o         | vertex_x/y/z_i, offset_x/z_i
//  result   | valid_o (strobe)        | plot_o, pixel_x/y_o, pixel_address_o,
//           |                         | color_out_o, depth_zero_o
//  config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// one vertex per cycle sustained; valid_o for a vertex rises once its start beat has passed
// the front register, the queue, stage 0, the divider pipeline of one quotient bit per
// stage, stages a and b and the output register. reset clears the configuration to
// its defaults and empties the pipeline. busy_o only rises if the queue ahead of the
// back part fills, which it does not since the back part drains one beat per cycle.
`default_nettype none
module perspective_point_projector #(
  parameter int COORD_BITS  = ppp_pkg::COORD_BITS_DEF,
  parameter int SCREEN_BITS = ppp_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic signed [COORD_BITS-1:0]    vertex_x_i,
  input  wire logic signed [COORD_BITS-1:0]    vertex_y_i,
  input  wire logic signed [COORD_BITS-1:0]    vertex_z_i,
  input  wire logic signed [COORD_BITS-1:0]    offset_x_i,
  input  wire logic signed [COORD_BITS-1:0]    offset_z_i,
  output logic                                 valid_o,
  output logic                                 plot_o,
  output logic [SCREEN_BITS-1:0]               pixel_x_o,
  output logic [SCREEN_BITS-1:0]               pixel_y_o,
  output logic [ppp_pkg::ADDR_W-1:0]           pixel_address_o,
  output logic [ppp_pkg::COLOR_W-1:0]          color_out_o,
  output logic                                 depth_zero_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ppp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ppp_pkg::*;

  localparam int SW = COORD_BITS + 1;
  localparam int PW = SW + SCREEN_BITS + 1;
  localparam int FW = 2 * PW + SW;

  logic [SCREEN_BITS-1:0] width_q, height_q, pitch_q, scale_q;
  logic [COLOR_W-1:0]     color_q;
  logic                   cfg_we;

  fifo_status_t  stat;
  logic          push, pop;
  logic [FW-1:0] fdata, qdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_BITS'(WIDTH_RST);
      height_q <= SCREEN_BITS'(HEIGHT_RST);
      pitch_q  <= SCREEN_BITS'(PITCH_RST);
      scale_q  <= SCREEN_BITS'(SCALE_RST);
      color_q  <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[SCREEN_BITS-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[SCREEN_BITS-1:0];
        REG_PITCH:  pitch_q  <= cfg_data_i[SCREEN_BITS-1:0];
        REG_SCALE:  scale_q  <= cfg_data_i[SCREEN_BITS-1:0];
        REG_COLOR:  color_q  <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_front #(
    .COORD_BITS  (COORD_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .vertex_z_i (vertex_z_i),
    .offset_x_i (offset_x_i),
    .offset_z_i (offset_z_i),
    .scale_i    (scale_q),
    .stat_i     (stat),
    .busy_o     (busy_o),
    .push_o     (push),
    .data_o     (fdata)
  );

  ppp_fifo #(
    .WIDTH (FW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fdata),
    .pop_i  (pop),
    .data_o (qdata),
    .stat_o (stat)
  );

  ppp_back #(
    .COORD_BITS  (COORD_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stat_i          (stat),
    .data_i          (qdata),
    .pop_o           (pop),
    .width_i         (width_q),
    .height_i        (height_q),
    .pitch_i         (pitch_q),
    .color_i         (color_q),
    .valid_o         (valid_o),
    .plot_o          (plot_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .color_out_o     (color_out_o),
    .depth_zero_o    (depth_zero_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ppp_checker.sv -----
// ppp_checker: port-level assertions for perspective_point_projector, with its bind
// depends on ppp_pkg
`default_nettype none
module ppp_checker #(
  parameter int SCREEN_BITS = ppp_pkg::SCREEN_BITS_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            busy_o,
  input wire logic                            valid_o,
  input wire logic                            plot_o,
  input wire logic [SCREEN_BITS-1:0]          pixel_x_o,
  input wire logic [SCREEN_BITS-1:0]          pixel_y_o,
  input wire logic [ppp_pkg::ADDR_W-1:0]      pixel_address_o,
  input wire logic                            depth_zero_o
);
  import ppp_pkg::*;

  // a zero depth beat is never plotted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && depth_zero_o |-> !plot_o)
    else $error("plot with zero depth");

  // unplotted beats carry a cleared position and address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !plot_o |-> pixel_x_o == '0 && pixel_y_o == '0 && pixel_address_o == '0)
    else $error("unplotted beat with nonzero position");

  // no result beat right after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !valid_o)
    else $error("result beat right after reset");

  // the queue drains every cycle, so vertices are never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!busy_o) |-> !busy_o)
    else $error("busy raised");

endmodule

bind perspective_point_projector ppp_checker #(
  .SCREEN_BITS (SCREEN_BITS)
) u_ppp_checker (.*);
`default_nettype wire
